/* sv/krt_pkg.sv */
// Shared types and constants for the keyed record table.
// Used by the top level, the port checker and the testbench; depends on nothing.
package krt_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_BITS_DEF = 64;

   localparam int REQ_KEY_W = 64;
   localparam int VALUE_W   = 10;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;

   typedef enum logic {
      OP_UPSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_DELETED  = 3'd2,
      ST_MISSING  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

endpackage

/* sv/krt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instantiated by the keyed record table top level.
module krt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* sv/keyed_record_table_upsert_delete.sv */
// Top level of the keyed record table: sequencer, shared key comparator and counters.
// Depends on krt_pkg and krt_ram.
//
// Usage: the request channel (req_*) carries one operation per transfer: an upsert
// (insert or update of the five values under a key) or a delete of a key. Each
// request yields exactly one response transfer on rsp_* with a status and the
// number of valid records after the operation.
// Each request is handled by one key comparator that walks the key RAM one entry
// per cycle, so its cost is set by CAPACITY and the RAM's registered read port.
// The response becomes valid after the scan and the S_LAST and S_DECIDE states,
// and the block returns to idle in the cycle after the response transfer.
// req_stall is high from the request transfer until the response is taken.
// While the receiver holds rsp_stall high, the response stays on the ports
// unchanged and no new request is taken.
// After reset the block runs a clearing pass over every entry of the key RAM
// to drop every valid mark; req_stall stays high during that pass.
module keyed_record_table_upsert_delete #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = krt_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [krt_pkg::REQ_KEY_W-1:0] req_record_key,
   input  logic [krt_pkg::VALUE_W-1:0]   req_value_a,
   input  logic [krt_pkg::VALUE_W-1:0]   req_value_b,
   input  logic [krt_pkg::VALUE_W-1:0]   req_value_c,
   input  logic [krt_pkg::VALUE_W-1:0]   req_value_d,
   input  logic [krt_pkg::VALUE_W-1:0]   req_value_e,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [krt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [krt_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import krt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int KW    = KEY_BITS + 1;
   localparam int VW    = 5 * VALUE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DECIDE,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   op_type               op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [VW-1:0]        val_ff, val_in;

   logic                 key_we;
   logic [IDX_W-1:0]     key_wa;
   logic [KW-1:0]        key_wd;
   logic [KW-1:0]        key_rd;
   logic                 val_we;
   logic [IDX_W-1:0]     val_wa;
   logic                 match;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   // Each key RAM word carries its valid mark in the top bit.
   krt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   // The stored values are never returned, so the read port stays open.
   krt_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_ff),
      .rd_addr (val_wa),
      .rd_data ()
   );

   assign match = key_rd[KEY_BITS] && (key_rd[KEY_BITS-1:0] == key_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      cmp_idx_in   = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      key_we       = 1'b0;
      key_wa       = idx_ff;
      key_wd       = '0;
      val_we       = 1'b0;
      val_wa       = hit_idx_ff;

      // The comparator looks at the entry read in the previous cycle.
      if (pend_ff) begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!key_rd[KEY_BITS] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            key_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               key_in   = req_record_key[KEY_BITS-1:0];
               val_in   = {req_value_e, req_value_d, req_value_c, req_value_b, req_value_a};
               hit_in   = 1'b0;
               free_in  = 1'b0;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_LAST;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (op_ff == OP_UPSERT) begin
               if (hit_ff) begin
                  val_we    = 1'b1;
                  status_in = ST_UPDATED;
               end else if (free_ff) begin
                  key_we    = 1'b1;
                  key_wa    = free_idx_ff;
                  key_wd    = {1'b1, key_ff};
                  val_we    = 1'b1;
                  val_wa    = free_idx_ff;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  status_in = ST_INSERTED;
               end else begin
                  status_in = ST_FULL;
               end
            end else begin
               if ((cnt_ff == '0) || !hit_ff) begin
                  status_in = ST_MISSING;
               end else begin
                  key_we    = 1'b1;
                  key_wa    = hit_idx_ff;
                  key_wd    = {1'b0, key_ff};
                  cnt_in    = cnt_ff - CNT_W'(1);
                  status_in = ST_DELETED;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
   end

   assign cnt_ext         = {{COUNT_W{1'b0}}, cnt_ff};
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = cnt_ext[COUNT_W-1:0];

endmodule

/* sv/krt_checker.sv */
// Port-level checker for the keyed record table and its bind to the top level.
// Depends on krt_pkg; sees only the top level's ports.
module krt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [krt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [krt_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import krt_pkg::*;

   // The clearing pass keeps requests out right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

   // A request transfer closes the request side at once.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open after a request transfer");

   // No new request is taken while a response is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while a response waits");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL))
      else $error("response status out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind keyed_record_table_upsert_delete krt_checker u_krt_checker (.*);

/* dv/krt_result_checker.sv */
`timescale 1ns / 1ps
// Response checker for the keyed record table: keeps a shadow copy of the table
// from observed request transfers and checks each response transfer against it.
// Depends on krt_pkg.
module krt_result_checker #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = krt_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_operation,
   input  logic [krt_pkg::REQ_KEY_W-1:0] req_record_key,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [krt_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [krt_pkg::COUNT_W-1:0]   rsp_entry_count,
   output int                            error_count,
   output int                            pending,
   output int                            checked
);
   import krt_pkg::*;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } table_outcome_type;

   logic [KEY_BITS-1:0] shadow_keys[CAPACITY];
   bit                  shadow_live[CAPACITY];
   int                  shadow_count;
   table_outcome_type   expected_outcomes[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   // The five values are stored by the block but never reach the response,
   // so only keys and occupancy are mirrored here.
   function automatic table_outcome_type apply_table_op(input op_type op,
                                                        input logic [REQ_KEY_W-1:0] raw_key);
      logic [KEY_BITS-1:0] key;
      int hit;
      int free_slot;
      table_outcome_type result;
      key = raw_key[KEY_BITS-1:0];
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (shadow_live[i] && shadow_keys[i] == key && hit < 0) hit = i;
         if (!shadow_live[i] && free_slot < 0) free_slot = i;
      end
      if (op == OP_UPSERT) begin
         if (hit >= 0) begin
            result.status = ST_UPDATED;
         end else if (free_slot >= 0) begin
            // New keys always land in the lowest free slot.
            shadow_keys[free_slot] = key;
            shadow_live[free_slot] = 1'b1;
            shadow_count++;
            result.status = ST_INSERTED;
         end else begin
            result.status = ST_FULL;
         end
      end else if (hit < 0) begin
         result.status = ST_MISSING;
      end else begin
         shadow_live[hit] = 1'b0;
         shadow_count--;
         result.status = ST_DELETED;
      end
      result.count = shadow_count[COUNT_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      table_outcome_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) shadow_live[i] = 1'b0;
         shadow_count = 0;
         expected_outcomes.delete();
      end else begin
         // Responses are checked before the request of the same edge is queued.
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("response status %0d count %0d with none expected",
                                         rsp_status, rsp_entry_count));
            end else begin
               want = expected_outcomes.pop_front();
               checked++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d (%s)", rsp_status,
                                            want.status, want.status.name()));
               if (rsp_entry_count !== want.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_entry_count, want.count));
            end
         end
         if (req_valid && !req_stall)
            expected_outcomes.push_back(apply_table_op(op_type'(req_operation),
                                                       req_record_key));
      end
      pending <= expected_outcomes.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the keyed record table testbench: clock, reset, request stimulus and
// response back-pressure. Depends on krt_pkg, the block and krt_result_checker.
module tb_top;
   import krt_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEF;
   localparam int POOL_SIZE      = 32;
   localparam int PHASE_ITEMS    = 425;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 2 * (CAPACITY + 3);
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [REQ_KEY_W-1:0]  req_record_key;
   logic [VALUE_W-1:0]    req_value_a;
   logic [VALUE_W-1:0]    req_value_b;
   logic [VALUE_W-1:0]    req_value_c;
   logic [VALUE_W-1:0]    req_value_d;
   logic [VALUE_W-1:0]    req_value_e;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_entry_count;

   int error_count;
   int pending;
   int checked;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   n_upserts = 0;
   int   n_deletes = 0;

   logic [REQ_KEY_W-1:0] key_pool[POOL_SIZE];

   keyed_record_table_upsert_delete u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_record_key  (req_record_key),
      .req_value_a     (req_value_a),
      .req_value_b     (req_value_b),
      .req_value_c     (req_value_c),
      .req_value_d     (req_value_d),
      .req_value_e     (req_value_e),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   krt_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_record_key  (req_record_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .error_count     (error_count),
      .pending         (pending),
      .checked         (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off counted here once requested.
   always @(posedge clock) begin
      if (hold_request) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Watchdog: no transfer in %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [49:0] random_values();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[49:0];
   endfunction

   // Returns at the edge where the request transfer takes place.
   task automatic send_request(input op_type op, input logic [REQ_KEY_W-1:0] key,
                               input logic [49:0] vals);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_record_key <= key;
      req_value_a    <= vals[9:0];
      req_value_b    <= vals[19:10];
      req_value_c    <= vals[29:20];
      req_value_d    <= vals[39:30];
      req_value_e    <= vals[49:40];
      if (op == OP_DELETE) n_deletes++;
      else n_upserts++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly valid traffic on a pool of keys, plus deletes of near-miss and
   // unrelated keys that must come back as not found.
   task automatic run_random_phase(input int del_pct, input int count);
      logic [REQ_KEY_W-1:0] key;
      op_type op;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         key = key_pool[$urandom_range(POOL_SIZE - 1)];
         if (pick < 8) begin
            op = OP_DELETE;
            key[$urandom_range(REQ_KEY_W - 1)] ^= 1'b1;
         end else if (pick < 12) begin
            op = OP_DELETE;
            key = {$urandom, $urandom};
         end else begin
            op = ($urandom_range(99) < del_pct) ? OP_DELETE : OP_UPSERT;
         end
         send_request(op, key, random_values());
      end
   endtask

   initial begin
      int settle_wait;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operation  <= OP_UPSERT;
      req_record_key <= '0;
      req_value_a    <= '0;
      req_value_b    <= '0;
      req_value_c    <= '0;
      req_value_d    <= '0;
      req_value_e    <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme keys and values, update, missing key,
      // filling to capacity, full table, update while full, slot reuse.
      send_request(OP_DELETE, key_pool[0], '0);
      send_request(OP_UPSERT, key_pool[0], '0);
      send_request(OP_UPSERT, key_pool[1], '1);
      send_request(OP_UPSERT, key_pool[0], '1);
      send_request(OP_DELETE, key_pool[31], '1);
      send_request(OP_DELETE, key_pool[1], '0);
      for (int i = 2; i <= 16; i++) send_request(OP_UPSERT, key_pool[i], random_values());
      send_request(OP_UPSERT, key_pool[17], random_values());
      send_request(OP_UPSERT, key_pool[9], {5{10'h2AA}});
      send_request(OP_DELETE, key_pool[5], '0);
      send_request(OP_UPSERT, key_pool[18], {5{10'h155}});
      pause_until_drained();

      send_idle_pct = 0;
      stall_pct = 0;
      run_random_phase(30, PHASE_ITEMS);

      // The response is held off while the sender keeps offering requests.
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      run_random_phase(30, 12);
      pause_until_drained();

      send_idle_pct = 77;
      stall_pct = 0;
      run_random_phase(85, PHASE_ITEMS);
      pause_until_drained();

      send_idle_pct = 0;
      stall_pct = 77;
      run_random_phase(15, PHASE_ITEMS);
      pause_until_drained();

      send_idle_pct = 21;
      stall_pct = 21;
      run_random_phase(50, PHASE_ITEMS);

      req_valid <= 1'b0;
      settle_wait = 0;
      @(posedge clock);
      while (pending != 0 && settle_wait < WATCHDOG_LIMIT) begin
         @(posedge clock);
         settle_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d upserts, %0d deletes), %0d responses checked.",
               n_upserts + n_deletes, n_upserts, n_deletes, checked);
      $display("Traffic ran without idling, with sparse requests, with heavy stalls, mixed, %s",
               "and through a long response hold-off, filling and draining the table.");
      if (pending != 0) $display("%0d expected responses never arrived", pending);
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
